/* src/mca_pkg.sv */
// Shared types and constants for the motion classifier alarm.
// No dependencies; imported by every module of the block.
package mca_pkg;

    localparam int AXIS_W    = 13;
    localparam int THRESH_W  = 13;
    localparam int COUNT_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [1:0] {
        CLASS_NORMAL    = 2'd0,
        CLASS_SHAKE     = 2'd1,
        CLASS_VIBRATION = 2'd2,
        CLASS_TILT      = 2'd3
    } motion_class_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TILT_THRESHOLD      = 3'd0,
        CFG_VIBRATION_THRESHOLD = 3'd1,
        CFG_SHAKE_THRESHOLD     = 3'd2,
        CFG_ASSERT_COUNT        = 3'd3,
        CFG_CLEAR_COUNT         = 3'd4
    } cfg_index_t;

    localparam logic [THRESH_W-1:0] TILT_RESET      = 13'd2048;
    localparam logic [THRESH_W-1:0] VIBRATION_RESET = 13'd1024;
    localparam logic [THRESH_W-1:0] SHAKE_RESET     = 13'd256;
    localparam logic [COUNT_W-1:0]  ASSERT_RESET    = 8'd3;
    localparam logic [COUNT_W-1:0]  CLEAR_RESET     = 8'd3;

    typedef struct packed {
        logic [THRESH_W-1:0] tilt;
        logic [THRESH_W-1:0] vibration;
        logic [THRESH_W-1:0] shake;
    } thresholds_t;

endpackage

/* src/mca_classify.sv */
// Combinational motion classification of one accelerometer reading.
// Depends on mca_pkg for widths, thresholds_t and motion_class_t.
module mca_classify (
    input  logic                                reading_valid,
    input  logic signed [mca_pkg::AXIS_W-1:0]   accel_x,
    input  logic signed [mca_pkg::AXIS_W-1:0]   accel_y,
    input  logic signed [mca_pkg::AXIS_W-1:0]   accel_z,
    input  logic                                have_previous,
    input  logic signed [mca_pkg::AXIS_W-1:0]   last_x,
    input  logic signed [mca_pkg::AXIS_W-1:0]   last_y,
    input  logic signed [mca_pkg::AXIS_W-1:0]   last_z,
    input  mca_pkg::thresholds_t                thresh,
    output mca_pkg::motion_class_t              motion_class
);
    import mca_pkg::*;

    logic signed [AXIS_W:0] dx;
    logic signed [AXIS_W:0] dy;
    logic signed [AXIS_W:0] dz;
    logic [AXIS_W-1:0] mag_dx;
    logic [AXIS_W-1:0] mag_dy;
    logic [AXIS_W-1:0] mag_dz;
    logic [AXIS_W-1:0] mag_x;
    logic [AXIS_W-1:0] mag_y;
    logic [AXIS_W-1:0] change;
    logic signed [AXIS_W:0] ext_x;
    logic signed [AXIS_W:0] ext_y;
    logic signed [AXIS_W:0] neg_x;
    logic signed [AXIS_W:0] neg_y;
    logic signed [AXIS_W:0] neg_dx;
    logic signed [AXIS_W:0] neg_dy;
    logic signed [AXIS_W:0] neg_dz;

    always_comb begin
        ext_x = {accel_x[AXIS_W-1], accel_x};
        ext_y = {accel_y[AXIS_W-1], accel_y};
        neg_x = -ext_x;
        neg_y = -ext_y;
        // A magnitude of 4096 still fits the unsigned 13-bit range.
        mag_x = ext_x[AXIS_W] ? neg_x[AXIS_W-1:0] : ext_x[AXIS_W-1:0];
        mag_y = ext_y[AXIS_W] ? neg_y[AXIS_W-1:0] : ext_y[AXIS_W-1:0];

        dx = ext_x - {last_x[AXIS_W-1], last_x};
        dy = ext_y - {last_y[AXIS_W-1], last_y};
        dz = {accel_z[AXIS_W-1], accel_z} - {last_z[AXIS_W-1], last_z};
        neg_dx = -dx;
        neg_dy = -dy;
        neg_dz = -dz;
        mag_dx = dx[AXIS_W] ? neg_dx[AXIS_W-1:0] : dx[AXIS_W-1:0];
        mag_dy = dy[AXIS_W] ? neg_dy[AXIS_W-1:0] : dy[AXIS_W-1:0];
        mag_dz = dz[AXIS_W] ? neg_dz[AXIS_W-1:0] : dz[AXIS_W-1:0];

        change = '0;
        if (have_previous) begin
            change = mag_dx;
            if (mag_dy > change) change = mag_dy;
            if (mag_dz > change) change = mag_dz;
        end

        if (!reading_valid) begin
            motion_class = CLASS_NORMAL;
        end else if (mag_x >= thresh.tilt || mag_y >= thresh.tilt) begin
            motion_class = CLASS_TILT;
        end else if (change >= thresh.vibration) begin
            motion_class = CLASS_VIBRATION;
        end else if (change >= thresh.shake) begin
            motion_class = CLASS_SHAKE;
        end else begin
            motion_class = CLASS_NORMAL;
        end
    end

endmodule

/* src/motion_classifier_alarm.sv */
// Top level of the motion classifier alarm: input register, state, debounce
// counters and result register. Depends on mca_pkg and mca_classify.
//
//   channel | prefix | handshake         | payload
//   input   | s_     | s_valid / s_ready | reading_valid, accel_x, accel_y, accel_z
//   result  | m_     | m_valid / m_ready | motion_class, alarm_on, reading_ok
//   config  | cfg_   | cfg_we            | cfg_index, cfg_data
//
// Each word passes through the input register, then through classification and
// the counter update into the result register. A new word is taken every cycle
// while s_ready is high; the previous-reading and counter state are updated as
// a word moves into the result register, so the next word sees them.
// Reset (aresetn low at a clock edge) empties both registers and loads defaults.
// A stalled result holds the input register; s_ready falls only when both are full.
module motion_classifier_alarm (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_reading_valid,
    input  logic signed [mca_pkg::AXIS_W-1:0]     s_accel_x,
    input  logic signed [mca_pkg::AXIS_W-1:0]     s_accel_y,
    input  logic signed [mca_pkg::AXIS_W-1:0]     s_accel_z,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [1:0]                            m_motion_class,
    output logic                                  m_alarm_on,
    output logic                                  m_reading_ok,
    input  logic                                  cfg_we,
    input  logic [mca_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mca_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import mca_pkg::*;

    thresholds_t        thresh_reg;
    logic [COUNT_W-1:0] assert_count_reg;
    logic [COUNT_W-1:0] clear_count_reg;

    logic                     in_valid_reg;
    logic                     in_reading_valid_reg;
    logic signed [AXIS_W-1:0] in_x_reg;
    logic signed [AXIS_W-1:0] in_y_reg;
    logic signed [AXIS_W-1:0] in_z_reg;

    logic                     have_previous_reg;
    logic signed [AXIS_W-1:0] last_x_reg;
    logic signed [AXIS_W-1:0] last_y_reg;
    logic signed [AXIS_W-1:0] last_z_reg;
    logic [COUNT_W-1:0]       high_run_reg;
    logic [COUNT_W-1:0]       quiet_run_reg;
    logic                     alarm_reg;
    logic [COUNT_W-1:0]       high_run_next;
    logic [COUNT_W-1:0]       quiet_run_next;
    logic                     alarm_next;

    logic          out_valid_reg;
    motion_class_t out_class_reg;
    logic          out_alarm_reg;
    logic          out_ok_reg;

    motion_class_t cur_class;
    logic          is_high;
    logic          advance;
    logic          s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    assign m_valid        = out_valid_reg;
    assign m_motion_class = out_class_reg;
    assign m_alarm_on     = out_alarm_reg;
    assign m_reading_ok   = out_ok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg.tilt      <= TILT_RESET;
            thresh_reg.vibration <= VIBRATION_RESET;
            thresh_reg.shake     <= SHAKE_RESET;
            assert_count_reg     <= ASSERT_RESET;
            clear_count_reg      <= CLEAR_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_TILT_THRESHOLD:      thresh_reg.tilt      <= cfg_data;
                CFG_VIBRATION_THRESHOLD: thresh_reg.vibration <= cfg_data;
                CFG_SHAKE_THRESHOLD:     thresh_reg.shake     <= cfg_data;
                CFG_ASSERT_COUNT:        assert_count_reg     <= cfg_data[COUNT_W-1:0];
                CFG_CLEAR_COUNT:         clear_count_reg      <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    mca_classify u_classify (
        .reading_valid (in_reading_valid_reg),
        .accel_x       (in_x_reg),
        .accel_y       (in_y_reg),
        .accel_z       (in_z_reg),
        .have_previous (have_previous_reg),
        .last_x        (last_x_reg),
        .last_y        (last_y_reg),
        .last_z        (last_z_reg),
        .thresh        (thresh_reg),
        .motion_class  (cur_class)
    );

    // Invalid readings classify as normal, so they are never high.
    assign is_high = (cur_class == CLASS_VIBRATION) || (cur_class == CLASS_TILT);

    always_comb begin
        high_run_next  = high_run_reg;
        quiet_run_next = quiet_run_reg;
        if (is_high) begin
            if (high_run_reg < assert_count_reg) high_run_next = high_run_reg + 1'b1;
            quiet_run_next = '0;
        end else begin
            if (quiet_run_reg < clear_count_reg) quiet_run_next = quiet_run_reg + 1'b1;
            high_run_next = '0;
        end

        alarm_next = alarm_reg;
        if (!alarm_reg && high_run_next >= assert_count_reg) begin
            alarm_next = 1'b1;
        end else if (alarm_reg && quiet_run_next >= clear_count_reg) begin
            alarm_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_reading_valid_reg <= s_reading_valid;
            in_x_reg             <= s_accel_x;
            in_y_reg             <= s_accel_y;
            in_z_reg             <= s_accel_z;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_previous_reg <= 1'b0;
            last_x_reg        <= '0;
            last_y_reg        <= '0;
            last_z_reg        <= '0;
            high_run_reg      <= '0;
            quiet_run_reg     <= '0;
            alarm_reg         <= 1'b0;
        end else if (advance) begin
            have_previous_reg <= in_reading_valid_reg;
            if (in_reading_valid_reg) begin
                last_x_reg <= in_x_reg;
                last_y_reg <= in_y_reg;
                last_z_reg <= in_z_reg;
            end
            high_run_reg  <= high_run_next;
            quiet_run_reg <= quiet_run_next;
            alarm_reg     <= alarm_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_class_reg <= cur_class;
            out_alarm_reg <= alarm_next;
            out_ok_reg    <= in_reading_valid_reg;
        end
    end

endmodule

/* src/mca_checker.sv */
// Port-level checks for motion_classifier_alarm, attached by bind.
// Depends on mca_pkg for widths and the motion class codes.
module mca_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [1:0]                          m_motion_class,
    input logic                                m_alarm_on,
    input logic                                m_reading_ok
);
    import mca_pkg::*;

    // A held result word keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_motion_class)
            && $stable(m_alarm_on) && $stable(m_reading_ok))
        else $error("result word changed while stalled");

    // A failed reading is always reported as normal motion.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_reading_ok |-> m_motion_class == CLASS_NORMAL)
        else $error("invalid reading classified as motion");

    // With the result side empty the block must take a new word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while result register is empty");

    // Reset leaves no result pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

endmodule

bind motion_classifier_alarm mca_checker u_mca_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_motion_class (m_motion_class),
    .m_alarm_on     (m_alarm_on),
    .m_reading_ok   (m_reading_ok)
);
